>>> hw/rtl/position_pid_with_safety_cutoffs_assert.svh
// assertion macros for the position pid controller
// expects clk and rst in the scope of the including module
`ifndef POSITION_PID_WITH_SAFETY_CUTOFFS_ASSERT_SVH
`define POSITION_PID_WITH_SAFETY_CUTOFFS_ASSERT_SVH

// condition must hold at every edge outside reset
`define PPID_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ppid assertion failed");

// consequent must hold whenever the antecedent holds
`define PPID_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppid assertion failed");

`endif

>>> hw/rtl/ppid_pkg.sv
// shared types and constants for the position pid controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ppid_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int ERR_BITS      = SAMPLE_BITS + 1;
  localparam int DIFF_BITS     = ERR_BITS + 1;
  localparam int SUM_BITS      = 24;
  localparam int GAIN_BITS     = 16;
  localparam int DUTY_BITS     = 10;
  localparam int SETTLE_BITS   = 16;
  localparam int COOL_BITS     = 8;
  localparam int Q_SHIFT       = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam int P_BITS   = GAIN_BITS + 1 + ERR_BITS;
  localparam int I_BITS   = GAIN_BITS + 1 + SUM_BITS;
  localparam int D_BITS   = GAIN_BITS + 1 + DIFF_BITS;
  localparam int ACC_BITS = I_BITS + 2;

  localparam logic [COOL_BITS-1:0] FAULT_HOLD = COOL_BITS'(200);
  localparam logic [DUTY_BITS-1:0] DUTY_MAX   = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEGRAL_GAIN = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_POS_MAX       = 3'd3,
    REG_POS_MIN       = 3'd4,
    REG_DEAD_BAND     = 3'd5,
    REG_SETTLE_TICKS  = 3'd6,
    REG_FAULT_LIMIT   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_BITS-1:0]   prop_gain;
    logic [GAIN_BITS-1:0]   integral_gain;
    logic [GAIN_BITS-1:0]   deriv_gain;
    logic [SAMPLE_BITS-1:0] pos_max;
    logic [SAMPLE_BITS-1:0] pos_min;
    logic [SAMPLE_BITS-1:0] dead_band;
    logic [SETTLE_BITS-1:0] settle_ticks;
    logic [SAMPLE_BITS-1:0] fault_limit;
  } cfg_t;

  // error terms and drive decisions out of the front stage
  typedef struct packed {
    logic                        en;
    logic signed [ERR_BITS-1:0]  err;
    logic signed [DIFF_BITS-1:0] diff;
    logic signed [SUM_BITS-1:0]  sum;
    logic                        right;
    logic                        left;
    logic                        zero_duty;
    logic                        inb;
    logic                        fcut;
  } front_t;

  // weighted terms out of the multiplier stage
  typedef struct packed {
    logic                     en;
    logic signed [P_BITS-1:0] p_term;
    logic signed [I_BITS-1:0] i_term;
    logic signed [D_BITS-1:0] d_term;
    logic                     right;
    logic                     left;
    logic                     zero_duty;
    logic                     inb;
    logic                     fcut;
  } mult_t;

endpackage

`default_nettype wire

>>> hw/rtl/ppid_in_if.sv
// sample channel: valid/ready handshake with the tick payload
// depends on ppid_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ppid_in_if;
  import ppid_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] ref_sample;
  logic [SAMPLE_BITS-1:0] fb_sample;
  logic                   enable;

  modport source (output valid, output ref_sample, output fb_sample, output enable,
                  input ready);
  modport sink   (input valid, input ref_sample, input fb_sample, input enable,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ppid_out_if.sv
// result channel: valid/ready handshake with the drive payload
// depends on ppid_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ppid_out_if;
  import ppid_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DUTY_BITS-1:0] duty;
  logic                 drive_right;
  logic                 drive_left;
  logic                 in_band;
  logic                 fault_cut;

  modport source (output valid, output duty, output drive_right, output drive_left,
                  output in_band, output fault_cut, input ready);
  modport sink   (input valid, input duty, input drive_right, input drive_left,
                  input in_band, input fault_cut, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ppid_cfg_regs.sv
// configuration register bank with plain write port
// depends on ppid_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppid_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [ppid_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [ppid_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output ppid_pkg::cfg_t                           cfg
);
  import ppid_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain     <= GAIN_BITS'(12800);
      cfg.integral_gain <= '0;
      cfg.deriv_gain    <= '0;
      cfg.pos_max       <= SAMPLE_BITS'(147);
      cfg.pos_min       <= SAMPLE_BITS'(89);
      cfg.dead_band     <= SAMPLE_BITS'(10);
      cfg.settle_ticks  <= SETTLE_BITS'(50);
      cfg.fault_limit   <= SAMPLE_BITS'(500);
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_PROP_GAIN:     cfg.prop_gain     <= cfg_data[GAIN_BITS-1:0];
        REG_INTEGRAL_GAIN: cfg.integral_gain <= cfg_data[GAIN_BITS-1:0];
        REG_DERIV_GAIN:    cfg.deriv_gain    <= cfg_data[GAIN_BITS-1:0];
        REG_POS_MAX:       cfg.pos_max       <= cfg_data[SAMPLE_BITS-1:0];
        REG_POS_MIN:       cfg.pos_min       <= cfg_data[SAMPLE_BITS-1:0];
        REG_DEAD_BAND:     cfg.dead_band     <= cfg_data[SAMPLE_BITS-1:0];
        REG_SETTLE_TICKS:  cfg.settle_ticks  <= cfg_data[SETTLE_BITS-1:0];
        REG_FAULT_LIMIT:   cfg.fault_limit   <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ppid_front.sv
// input register, error forming and loop state update
// depends on ppid_pkg and ppid_in_if
`timescale 1ns / 1ps
`default_nettype none

module ppid_front (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire ppid_pkg::cfg_t cfg,
  ppid_in_if.sink        sample_in,
  output logic           front_valid,
  input  wire logic      front_ready,
  output ppid_pkg::front_t front
);
  import ppid_pkg::*;

  // input register
  logic                   s0_valid;
  logic [SAMPLE_BITS-1:0] ref_q;
  logic [SAMPLE_BITS-1:0] fb_q;
  logic                   en_q;

  // loop state
  logic signed [ERR_BITS-1:0] prev_error, prev_error_next;
  logic signed [SUM_BITS-1:0] error_sum, error_sum_next;
  logic                       band_flag, band_flag_next;
  logic [SETTLE_BITS-1:0]     settle_count, settle_count_next;
  logic [COOL_BITS-1:0]       fault_cooldown, fault_cooldown_next;

  logic                        move;
  logic                        accept;
  logic [SAMPLE_BITS-1:0]      ref_hi, ref_c;
  logic signed [ERR_BITS-1:0]  err;
  logic [ERR_BITS-1:0]         err_abs;
  logic [SAMPLE_BITS-1:0]      err_mag;
  logic signed [DIFF_BITS-1:0] diff;
  logic signed [SUM_BITS:0]    sum_wide;
  logic signed [SUM_BITS-1:0]  sum_sat;
  logic                        right, lim_cut, in_db, fault_ok, fault, settled;
  logic [SETTLE_BITS-1:0]      cnt_tick;
  logic [COOL_BITS-1:0]        cool_tick;
  front_t                      front_d;

  assign move            = s0_valid && (!front_valid || front_ready);
  assign sample_in.ready = !s0_valid || move;
  assign accept          = sample_in.valid && sample_in.ready;

  always_comb begin
    ref_hi  = (ref_q > cfg.pos_max) ? cfg.pos_max : ref_q;
    ref_c   = (ref_hi < cfg.pos_min) ? cfg.pos_min : ref_hi;
    err     = $signed({1'b0, ref_c}) - $signed({1'b0, fb_q});
    err_abs = err[ERR_BITS-1] ? ERR_BITS'(-err) : ERR_BITS'(err);
    err_mag = err_abs[SAMPLE_BITS-1:0];
    diff    = $signed({err[ERR_BITS-1], err}) - $signed({prev_error[ERR_BITS-1], prev_error});

    sum_wide = $signed({error_sum[SUM_BITS-1], error_sum})
             + $signed({{(SUM_BITS + 1 - ERR_BITS){err[ERR_BITS-1]}}, err});
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      sum_sat = sum_wide[SUM_BITS] ? $signed({1'b1, {(SUM_BITS-1){1'b0}}})
                                   : $signed({1'b0, {(SUM_BITS-1){1'b1}}});
    end else begin
      sum_sat = sum_wide[SUM_BITS-1:0];
    end

    right   = ref_c > fb_q;
    lim_cut = (fb_q >= cfg.pos_max && right) || (fb_q <= cfg.pos_min && !right);
    in_db   = err_mag <= cfg.dead_band;
    fault_ok = fault_cooldown == '0;
    fault   = (err_mag > cfg.fault_limit) && fault_ok;

    // counters tick every sample, enabled or not
    cnt_tick  = (band_flag && settle_count != '1) ? settle_count + 1'b1 : settle_count;
    cool_tick = fault_ok ? fault_cooldown : fault_cooldown - 1'b1;

    if (en_q) begin
      settle_count_next   = (in_db && !band_flag) ? '0 : cnt_tick;
      fault_cooldown_next = fault ? FAULT_HOLD : cool_tick;
      band_flag_next      = in_db;
      prev_error_next     = err;
      error_sum_next      = sum_sat;
    end else begin
      settle_count_next   = cnt_tick;
      fault_cooldown_next = cool_tick;
      band_flag_next      = band_flag;
      prev_error_next     = prev_error;
      error_sum_next      = error_sum;
    end

    settled = in_db && (settle_count_next > cfg.settle_ticks);

    front_d.en        = en_q;
    front_d.err       = err;
    front_d.diff      = diff;
    front_d.sum       = sum_sat;
    front_d.right     = right && !settled && !fault;
    front_d.left      = !right && !settled && !fault;
    front_d.zero_duty = lim_cut || settled || fault;
    front_d.inb       = in_db && !settled;
    front_d.fcut      = fault;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid       <= 1'b0;
      front_valid    <= 1'b0;
      prev_error     <= '0;
      error_sum      <= '0;
      band_flag      <= 1'b0;
      settle_count   <= '0;
      fault_cooldown <= '0;
    end else begin
      if (accept) begin
        s0_valid <= 1'b1;
      end else if (move) begin
        s0_valid <= 1'b0;
      end
      if (move) begin
        front_valid    <= 1'b1;
        prev_error     <= prev_error_next;
        error_sum      <= error_sum_next;
        band_flag      <= band_flag_next;
        settle_count   <= settle_count_next;
        fault_cooldown <= fault_cooldown_next;
      end else if (front_ready) begin
        front_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ref_q <= sample_in.ref_sample;
      fb_q  <= sample_in.fb_sample;
      en_q  <= sample_in.enable;
    end
    if (move) begin
      front <= front_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ppid_mult.sv
// gain multiplier stage: three products into one register
// depends on ppid_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppid_mult (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ppid_pkg::cfg_t   cfg,
  input  wire logic        front_valid,
  output logic             front_ready,
  input  wire ppid_pkg::front_t front,
  output logic             mult_valid,
  input  wire logic        mult_ready,
  output ppid_pkg::mult_t  mult
);
  import ppid_pkg::*;

  logic  load;
  mult_t mult_d;

  assign front_ready = !mult_valid || mult_ready;
  assign load        = front_valid && front_ready;

  always_comb begin
    mult_d.en        = front.en;
    mult_d.p_term    = $signed({1'b0, cfg.prop_gain}) * front.err;
    mult_d.i_term    = $signed({1'b0, cfg.integral_gain}) * front.sum;
    mult_d.d_term    = $signed({1'b0, cfg.deriv_gain}) * front.diff;
    mult_d.right     = front.right;
    mult_d.left      = front.left;
    mult_d.zero_duty = front.zero_duty;
    mult_d.inb       = front.inb;
    mult_d.fcut      = front.fcut;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mult_valid <= 1'b0;
    end else if (load) begin
      mult_valid <= 1'b1;
    end else if (mult_ready) begin
      mult_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mult <= mult_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ppid_out.sv
// sum, q8 shift, magnitude and saturation into the result register
// depends on ppid_pkg and ppid_out_if
`timescale 1ns / 1ps
`default_nettype none

module ppid_out (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       mult_valid,
  output logic            mult_ready,
  input  wire ppid_pkg::mult_t mult,
  ppid_out_if.source      result_out
);
  import ppid_pkg::*;

  logic                       load;
  logic [DUTY_BITS-1:0]       held_duty;
  logic signed [ACC_BITS-1:0] acc, acc_sh;
  logic [ACC_BITS-1:0]        mag;
  logic [DUTY_BITS-1:0]       duty_pid, duty;

  assign mult_ready = !result_out.valid || result_out.ready;
  assign load       = mult_valid && mult_ready;

  always_comb begin
    acc    = ACC_BITS'(mult.p_term) + ACC_BITS'(mult.i_term) + ACC_BITS'(mult.d_term);
    acc_sh = acc >>> Q_SHIFT;
    // floor shift then magnitude rounds negative sums away from zero
    mag    = acc_sh[ACC_BITS-1] ? ACC_BITS'(-acc_sh) : ACC_BITS'(acc_sh);
    duty_pid = (mag > ACC_BITS'(DUTY_MAX)) ? DUTY_MAX : mag[DUTY_BITS-1:0];
    if (!mult.en) begin
      duty = held_duty;
    end else if (mult.zero_duty) begin
      duty = '0;
    end else begin
      duty = duty_pid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
      held_duty        <= '0;
    end else begin
      if (load) begin
        result_out.valid <= 1'b1;
      end else if (result_out.ready) begin
        result_out.valid <= 1'b0;
      end
      if (load && mult.en) begin
        held_duty <= duty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out.duty        <= duty;
      result_out.drive_right <= mult.en && mult.right;
      result_out.drive_left  <= mult.en && mult.left;
      result_out.in_band     <= mult.en && mult.inb;
      result_out.fault_cut   <= mult.en && mult.fcut;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/position_pid_with_safety_cutoffs.sv
// position pid with safety cutoffs: each accepted sample passes the stages below to the result
// throughput one word per cycle; each stage holds while its successor is full
// stages: input register, error/state update, gain products, sum and saturate
// while a result waits unread, new words enter only until the stages ahead of the result register fill
// reset (rst, synchronous) restores register defaults, clears loop state and empties the pipe
// no clearing pass: all state is in flip-flops
`timescale 1ns / 1ps
`default_nettype none

module position_pid_with_safety_cutoffs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [ppid_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [ppid_pkg::CFG_DATA_BITS-1:0] cfg_data,
  ppid_in_if.sink                                 sample_in,
  ppid_out_if.source                              result_out
);
  import ppid_pkg::*;

  `include "position_pid_with_safety_cutoffs_assert.svh"

  // live configuration; the user must rewrite it only while the pipe is idle, the block does not enforce this
  cfg_t   cfg;

  // front stage to multiplier stage
  logic   front_valid;
  logic   front_ready;
  front_t front;

  // multiplier stage to result stage
  logic   mult_valid;
  logic   mult_ready;
  mult_t  mult;

  ppid_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // clamp, error, integral, dead band / settle / fault decisions;
  // loop state moves once per word as it leaves the input register
  ppid_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .sample_in   (sample_in),
    .front_valid (front_valid),
    .front_ready (front_ready),
    .front       (front)
  );

  // the three gain products, registered before they are summed
  ppid_mult u_mult (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .front_valid (front_valid),
    .front_ready (front_ready),
    .front       (front),
    .mult_valid  (mult_valid),
    .mult_ready  (mult_ready),
    .mult        (mult)
  );

  // q8 sum, magnitude, saturation to 1023; held duty kept here so that
  // a disabled word sees the duty of the last enabled word ahead of it
  ppid_out u_out (
    .clk        (clk),
    .rst        (rst),
    .mult_valid (mult_valid),
    .mult_ready (mult_ready),
    .mult       (mult),
    .result_out (result_out)
  );

  // the bridge is never driven both ways
  `PPID_ASSERT_IMPL(a_dir_exclusive, result_out.valid,
                    !(result_out.drive_right && result_out.drive_left))
  // a fault cut removes all drive
  `PPID_ASSERT_IMPL(a_fault_off, result_out.valid && result_out.fault_cut,
                    result_out.duty == '0 && !result_out.drive_right && !result_out.drive_left)
  // in band and not cut by a fault means a direction is still selected
  `PPID_ASSERT_IMPL(a_band_drives, result_out.valid && result_out.in_band && !result_out.fault_cut,
                    result_out.drive_right || result_out.drive_left)

endmodule

`default_nettype wire
